// ===== hw/rtl/kcu_pkg.sv =====
`timescale 1ns / 1ps
package kcu_pkg;

    localparam int MAX_DIMS   = 8;
    localparam int MAX_POINTS = 65536;
    localparam int DIM_W      = 3;
    localparam int ND_W       = 4;
    localparam int CNT_W      = 17;
    localparam int SUM_W      = 48;
    localparam int VAL_W      = 32;
    localparam int SQ_W       = 64;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [DIM_W-1:0]        dim_index;
        logic signed [VAL_W-1:0] coord_value;
    } in_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]        out_dim;
        logic signed [VAL_W-1:0] new_center;
        logic [VAL_W-1:0]        shift_distance;
        logic [CNT_W-1:0]        point_count;
        logic                    empty_cluster;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

endpackage

// ===== hw/rtl/kmeans_centroid_update_core.sv =====
`timescale 1ns / 1ps
// Load and add transfers leave the core idle; ready stays high, so they can go back to back.
// Finish: per dimension, divider start, the 48-step serial divider, square and
// accumulate (an empty cluster skips the divider); then the square root (skipped when
// saturated), then one result per cycle as m_ready allows. Input ready
// returns once the last result is registered.
// Reset (aresetn low, synchronous): sums, count and centers clear, dims = 8.
module kmeans_centroid_update_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  kcu_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output kcu_pkg::out_item_t   m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_data
);
    import kcu_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DSTART = 7'b0000010,
        ST_DWAIT  = 7'b0000100,
        ST_SQ     = 7'b0001000,
        ST_ACC    = 7'b0010000,
        ST_ROOT   = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [ND_W-1:0]         dims_reg;
    logic [ND_W-1:0]         nd;
    logic [VAL_W-1:0]        center_reg [MAX_DIMS];
    logic [SUM_W-1:0]        sum_reg    [MAX_DIMS];
    logic [CNT_W-1:0]        pts_reg;

    // finish sequencer state
    logic [DIM_W-1:0]        idx_reg;
    logic [ND_W-1:0]         eidx_reg;
    logic [ND_W-1:0]         nd_reg;
    logic                    empty_reg;
    logic                    neg_reg;
    logic signed [VAL_W-1:0] q_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [SQ_W-1:0]         acc_reg;
    logic                    sat_reg;
    logic [VAL_W-1:0]        dist_reg;

    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    logic                    s_fire;
    logic [DIM_W-1:0]        sum_addr;
    logic [DIM_W-1:0]        cen_addr;
    logic [SUM_W-1:0]        sum_rd;
    logic signed [VAL_W-1:0] cen_rd;
    logic [SUM_W-1:0]        sum_mag;
    div_req_t                div_req;
    logic                    div_done;
    logic [SUM_W-1:0]        div_quo;
    logic signed [VAL_W-1:0] q_sat;
    logic signed [VAL_W:0]   diff;
    logic [VAL_W:0]          abs_diff;
    logic [SQ_W:0]           acc_sum;
    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [VAL_W-1:0]        sqrt_root;
    logic                    out_load;
    logic                    last_dim;
    logic                    emit_last;

    // dims register: 0 acts as 1, above MAX_DIMS acts as MAX_DIMS
    always_comb begin
        if (dims_reg == '0) begin
            nd = ND_W'(1);
        end else if (dims_reg > ND_W'(MAX_DIMS)) begin
            nd = ND_W'(MAX_DIMS);
        end else begin
            nd = dims_reg;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // one read port per store, address picked by phase
    assign sum_addr = s_ready ? s_data.dim_index : idx_reg;
    assign cen_addr = (state_reg == ST_EMIT) ? eidx_reg[DIM_W-1:0] : idx_reg;
    assign sum_rd   = sum_reg[sum_addr];
    assign cen_rd   = center_reg[cen_addr];

    assign sum_mag          = sum_rd[SUM_W-1] ? (~sum_rd + SUM_W'(1)) : sum_rd;
    assign div_req.start    = (state_reg == ST_DSTART) && !empty_reg;
    assign div_req.dividend = sum_mag;
    assign div_req.divisor  = pts_reg;

    kcu_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // truncated quotient, signed-32 saturation
    always_comb begin
        if (neg_reg) begin
            if (div_quo > SUM_W'(64'h8000_0000)) begin
                q_sat = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                q_sat = VAL_W'(~div_quo[VAL_W-1:0] + VAL_W'(1));
            end
        end else begin
            if (div_quo > SUM_W'(64'h7FFF_FFFF)) begin
                q_sat = {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
                q_sat = div_quo[VAL_W-1:0];
            end
        end
    end

    assign diff     = {q_reg[VAL_W-1], q_reg} - {cen_rd[VAL_W-1], cen_rd};
    assign abs_diff = diff[VAL_W] ? (VAL_W+1)'(0) - unsigned'(diff) : unsigned'(diff);
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, sq_reg};
    assign last_dim = ({1'b0, idx_reg} == nd_reg - ND_W'(1));

    // one start pulse as the last dimension is accumulated, unless the sum has saturated
    assign sqrt_start = (state_reg == ST_ACC) && last_dim && !sat_reg && !acc_sum[SQ_W];

    kcu_isqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc_sum[SQ_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign emit_last = (eidx_reg == nd_reg - ND_W'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.req_type == REQ_FINISH) begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: state_next = empty_reg ? ST_SQ : ST_DWAIT;
            ST_DWAIT:  if (div_done) state_next = ST_SQ;
            ST_SQ:     state_next = ST_ACC;
            ST_ACC:    state_next = last_dim ? ST_ROOT : ST_DSTART;
            ST_ROOT: begin
                if (sat_reg || sqrt_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:   if (out_load && emit_last) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dims_reg    <= ND_W'(MAX_DIMS);
            pts_reg     <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            eidx_reg    <= '0;
            for (int i = 0; i < MAX_DIMS; i++) begin
                center_reg[i] <= '0;
                sum_reg[i]    <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                dims_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        unique case (s_data.req_type)
                            REQ_LOAD: center_reg[s_data.dim_index] <= s_data.coord_value;
                            REQ_ADD: begin
                                if ({1'b0, s_data.dim_index} < nd
                                        && pts_reg < CNT_W'(MAX_POINTS)) begin
                                    sum_reg[s_data.dim_index] <= sum_rd
                                        + {{(SUM_W-VAL_W){s_data.coord_value[VAL_W-1]}},
                                           s_data.coord_value};
                                    if ({1'b0, s_data.dim_index} == nd - ND_W'(1)) begin
                                        pts_reg <= pts_reg + CNT_W'(1);
                                    end
                                end
                            end
                            REQ_FINISH: begin
                                idx_reg   <= '0;
                                eidx_reg  <= '0;
                                nd_reg    <= nd;
                                empty_reg <= (pts_reg == '0);
                                acc_reg   <= '0;
                                sq_reg    <= '0;
                                sat_reg   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DSTART: begin
                    neg_reg <= sum_rd[SUM_W-1];
                    q_reg   <= cen_rd;
                end
                ST_DWAIT: if (div_done) q_reg <= q_sat;
                ST_SQ: begin
                    center_reg[idx_reg] <= q_reg;
                    if (abs_diff[VAL_W]) begin
                        sat_reg <= 1'b1;
                        sq_reg  <= '0;
                    end else begin
                        sq_reg <= abs_diff[VAL_W-1:0] * abs_diff[VAL_W-1:0];
                    end
                end
                ST_ACC: begin
                    acc_reg <= acc_sum[SQ_W-1:0];
                    sq_reg  <= '0;
                    if (acc_sum[SQ_W]) begin
                        sat_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + DIM_W'(1);
                end
                ST_ROOT: begin
                    if (sat_reg) begin
                        dist_reg <= '1;
                    end else if (sqrt_done) begin
                        dist_reg <= sqrt_root;
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        m_data_reg.out_dim         <= eidx_reg[DIM_W-1:0];
                        m_data_reg.new_center      <= cen_rd;
                        m_data_reg.shift_distance  <= emit_last ? dist_reg : '0;
                        m_data_reg.point_count     <= pts_reg;
                        m_data_reg.empty_cluster   <= empty_reg;
                        m_data_reg.last            <= emit_last;
                        eidx_reg                   <= eidx_reg + ND_W'(1);
                        if (emit_last) begin
                            pts_reg <= '0;
                            for (int i = 0; i < MAX_DIMS; i++) begin
                                sum_reg[i] <= '0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("input ready while finish in progress");
    a_empty_no_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.empty_cluster |-> m_data.shift_distance == '0)
        else $error("empty cluster reported nonzero shift");
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DWAIT)
        else $error("divider finished outside wait state");
    a_sqrt_done_root: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> state_reg == ST_ROOT)
        else $error("square root finished outside root state");
`endif

endmodule

// ===== hw/rtl/kcu_divider.sv =====
`timescale 1ns / 1ps
module kcu_divider (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  kcu_pkg::div_req_t        req,
    output logic                     done,
    output logic [kcu_pkg::SUM_W-1:0] quotient
);
    import kcu_pkg::*;

    // restoring divide, one quotient bit per cycle
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] div_reg, div_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = trial >= {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
            cnt_next  = 6'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/kcu_isqrt.sv =====
`timescale 1ns / 1ps
module kcu_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [kcu_pkg::SQ_W-1:0]  radicand,
    output logic                      done,
    output logic [kcu_pkg::VAL_W-1:0] root
);
    import kcu_pkg::*;

    // digit-by-digit square root, two radicand bits per cycle
    logic [SQ_W-1:0] x_reg, x_next;
    logic [SQ_W-1:0] root_reg, root_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SQ_W-1:0] trial;

    always_comb begin
        trial     = root_reg + bit_reg;
        x_next    = x_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = radicand;
            root_next = '0;
            bit_next  = {2'b01, {(SQ_W-2){1'b0}}};
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (x_reg >= trial) begin
                x_next    = x_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_next == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = root_reg[VAL_W-1:0];

endmodule
